// ----- src/sdw_pkg.sv -----
package sdw_pkg;

  // Widths fixed by the item format.
  localparam int NUM_W = 32;
  localparam int POS_W = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 8;

  // Decimal digits needed for the largest 32-bit magnitude.
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W = BCD_DIGITS * 4;

  // Default number of digit registers on the display driver.
  localparam int DEF_DIGIT_COUNT = 8;

  // Driver register and data codes.
  localparam logic [ADDR_W-1:0] DECODE_REG = 4'd9;
  localparam logic [DATA_W-1:0] MINUS_CODE = 8'h0A;
  localparam logic [DATA_W-1:0] ALL_DECODED = 8'hFF;
  localparam logic [DATA_W-1:0] NONE_DECODED = 8'h00;

  // Input word: one value to print.
  typedef struct packed {
    logic [POS_W-1:0]        start_position;
    logic signed [NUM_W-1:0] number;
  } sdw_in_t;

  // Output word: one driver register write.
  typedef struct packed {
    logic [ADDR_W-1:0] reg_address;
    logic [DATA_W-1:0] reg_data;
    logic              last_write;
  } sdw_out_t;

  // Control from the sequencer to the BCD converter.
  typedef struct packed {
    logic start;
    logic pop;
  } sdw_conv_ctrl_t;

  // Status from the BCD converter.
  typedef struct packed {
    logic       done;
    logic [3:0] top_digit;
  } sdw_conv_sts_t;

endpackage

// ----- src/sdw_bcd.sv -----
module sdw_bcd import sdw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  sdw_conv_ctrl_t       ctrl,
  input  logic [NUM_W-1:0]     magnitude,
  output sdw_conv_sts_t        sts
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] bit_cnt;
  logic [NUM_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Conversion control: one binary bit enters per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_cnt <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 1'b1;
      if (bit_cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift registers: the binary value shifts into the BCD digits, and
  // finished digits leave from the top one at a time.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin <= magnitude;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[BCD_W-2:0], bin[NUM_W-1]};
      bin <= {bin[NUM_W-2:0], 1'b0};
    end else if (ctrl.pop) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

  assign sts.done = ~busy;
  assign sts.top_digit = bcd[BCD_W-1 -: 4];

endmodule

// ----- src/signed_decimal_digit_writer_top.sv -----
// Prints a signed 32-bit value on a seven-segment display driver as a run of
// register writes: decode mode to all digits, an optional minus, the decimal
// digits from the given position downward, and finally the configured decode
// mode. The 32-step bit-serial binary-to-BCD conversion runs under the header
// and sign writes. After it the sequencer steps through each of the ten BCD
// digits, leading zeros included, and then makes the closing write. A new input
// word is taken only once the previous run has finished.
module signed_decimal_digit_writer_top import sdw_pkg::*; #(
  parameter int DIGIT_COUNT = DEF_DIGIT_COUNT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sdw_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sdw_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_SIGN,
    S_WAIT,
    S_DIGIT,
    S_TAIL
  } state_t;

  state_t         state;
  logic [POS_W-1:0] pos;
  logic           neg;
  logic           started;
  logic [3:0]     dig_left;
  logic           decode_all;

  logic           accept;
  logic           out_free;
  logic           emit_now;
  logic           advance;
  logic           load_out;
  logic [POS_W-1:0] pos_in;
  logic [NUM_W-1:0] magnitude;
  sdw_conv_ctrl_t conv_ctrl;
  sdw_conv_sts_t  conv_sts;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_all <= 1'b0;
    end else if (cfg_we) begin
      decode_all <= cfg_data;
    end
  end

  // Input handshake, position clamp and magnitude.
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid & ~in_stall;
  assign pos_in = (in_data.start_position > POS_W'(DIGIT_COUNT)) ?
                  POS_W'(DIGIT_COUNT) : in_data.start_position;
  assign magnitude = in_data.number[NUM_W-1] ? (~in_data.number + 1'b1) : in_data.number;

  // A digit is shown once a nonzero digit has appeared, or for the units
  // digit, and only while a position remains.
  assign out_free = ~out_valid | ~out_stall;
  assign emit_now = (started | (conv_sts.top_digit != 4'd0) | (dig_left == 4'd1)) &
                    (pos != '0);
  assign advance = ~emit_now | out_free;

  // The output register takes a new word in these cases.
  assign load_out = out_free & ((state == S_HDR) |
                                ((state == S_SIGN) & neg & (pos != '0)) |
                                ((state == S_DIGIT) & emit_now) |
                                (state == S_TAIL));

  assign conv_ctrl.start = accept;
  assign conv_ctrl.pop = (state == S_DIGIT) & advance;

  sdw_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (conv_ctrl),
    .magnitude (magnitude),
    .sts       (conv_sts)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      started <= 1'b0;
    end else begin
      out_valid <= load_out | (out_valid & out_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos <= pos_in;
            neg <= in_data.number[NUM_W-1];
            state <= S_HDR;
          end
        end
        S_HDR: begin
          if (out_free) begin
            out_data <= '{reg_address: DECODE_REG, reg_data: ALL_DECODED, last_write: 1'b0};
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (neg && pos != '0) begin
            if (out_free) begin
              out_data <= '{reg_address: pos, reg_data: MINUS_CODE, last_write: 1'b0};
              pos <= pos - 1'b1;
              state <= S_WAIT;
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (conv_sts.done) begin
            dig_left <= 4'(BCD_DIGITS);
            started <= 1'b0;
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (advance) begin
            if (emit_now) begin
              out_data <= '{reg_address: pos, reg_data: {4'd0, conv_sts.top_digit},
                            last_write: 1'b0};
              pos <= pos - 1'b1;
            end
            started <= started | (conv_sts.top_digit != 4'd0);
            dig_left <= dig_left - 1'b1;
            if (dig_left == 4'd1) begin
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          if (out_free) begin
            out_data <= '{reg_address: DECODE_REG,
                          reg_data: decode_all ? ALL_DECODED : NONE_DECODED,
                          last_write: 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The converter is never mid-conversion while a new word can be taken.
  a_idle_conv_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> conv_sts.done)
    else $error("converter busy while sequencer idle");

  // The closing write is always the decode-mode register.
  a_last_is_decode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_write) |-> (out_data.reg_address == DECODE_REG))
    else $error("last write not to decode-mode register");

  // Digit register writes carry a BCD digit or the minus code.
  a_digit_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.reg_address != DECODE_REG) |->
    (out_data.reg_data <= MINUS_CODE))
    else $error("bad data on digit register write");

  // Digit writes never target position zero.
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.reg_address != '0))
    else $error("write to position zero");

endmodule
